### rtl/core/rsp_pkg.sv
`timescale 1ns / 1ps

package rsp_pkg;

	localparam int MAX_T_DEF  = 8;
	localparam int SYM_W      = 8;
	localparam int T_W        = 4;
	localparam int N_W        = T_W + 1;
	localparam int IDX_W      = 4;
	localparam int SCNT_W     = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [SYM_W-1:0] POLY8     = 8'h1D;
	localparam logic [SYM_W-1:0] POLY4     = 8'h13;
	localparam logic [SYM_W-1:0] SYM4_MASK = 8'h0F;
	localparam logic [SYM_W-1:0] ALPHA     = 8'h02;
	localparam logic [SYM_W-1:0] GF_ONE    = 8'h01;
	localparam logic [SYM_W-1:0] NSYM8     = 8'd255;
	localparam logic [SYM_W-1:0] NSYM4     = 8'd15;
	localparam logic [T_W-1:0]   T_RESET   = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIELD_SELECT       = 8'd0,
		REG_CORRECT_CAPABILITY = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [SYM_W-1:0] data_symbol;
		logic             last_symbol;
	} in_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] parity_symbol;
		logic [IDX_W-1:0] parity_index;
		logic             last_parity;
		logic             size_error;
	} out_item_t;

	typedef struct packed {
		logic upd;
		logic clr;
		logic load;
		logic ld_zero;
		logic shift;
	} par_ctl_t;

	typedef struct packed {
		logic init;
		logic step;
	} gen_ctl_t;

	// Multiplication in GF(256) when wide is set, otherwise in GF(16).
	function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
			input logic [SYM_W-1:0] b, input logic wide);
		logic [SYM_W-1:0] r;
		logic [SYM_W-1:0] x;
		logic [SYM_W-1:0] bb;
		r  = '0;
		x  = wide ? a : (a & SYM4_MASK);
		bb = wide ? b : (b & SYM4_MASK);
		for (int i = 0; i < SYM_W; i++) begin
			if (bb[i])
				r = r ^ x;
			if (wide)
				x = {x[SYM_W-2:0], 1'b0} ^ (x[SYM_W-1] ? POLY8 : '0);
			else
				x = {x[SYM_W-2:0], 1'b0} ^ (x[3] ? POLY4 : '0);
		end
		return wide ? r : (r & SYM4_MASK);
	endfunction

endpackage

### rtl/core/rs_parity_encoder.sv
`timescale 1ns / 1ps

// Systematic Reed-Solomon parity encoder over GF(256) or GF(16). One data symbol is
// taken per cycle while in_ready is high; the parity cells update together, so
// requests run at full rate. The symbol that completes a block loads all 2T parity
// symbols into an output shift bank, which drains one symbol per cycle while
// out_ready is high, as the next block streams in. A request that yields results,
// whether a completed block or a single size-error result, waits until the bank is
// empty or its final symbol leaves in the same cycle. After reset and after every
// configuration write the generator polynomial is rebuilt, one root per cycle, and
// no data request is taken meanwhile. Configuration requests are always accepted.
module rs_parity_encoder #(
	parameter int MAX_T = rsp_pkg::MAX_T_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rsp_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rsp_pkg::out_item_t             out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rsp_pkg::*;

	localparam int P     = 2 * MAX_T;
	localparam int SEL_W = $clog2(P);
	localparam int CNT_W = $clog2(P + 1);
	localparam int CAP16 = (MAX_T < 7) ? MAX_T : 7;

	logic              fs_q;
	logic [T_W-1:0]    t_q;
	logic [N_W-1:0]    t_lim;
	logic [N_W-1:0]    t_eff;
	logic [N_W-1:0]    n;
	logic [N_W-1:0]    n_m1;
	logic [CNT_W-1:0]  n_cnt;
	logic              cfg_hit;

	logic              gen_busy_q;
	logic [N_W-1:0]    gen_cnt_q;
	logic [SYM_W-1:0]  root_q;
	gen_ctl_t          gctl;
	par_ctl_t          pctl;

	logic [SYM_W-1:0]  g    [P];
	logic [SYM_W-1:0]  p    [P];
	logic [SYM_W-1:0]  slot [P];

	logic [SCNT_W-1:0] scnt_q;
	logic [SYM_W-1:0]  sym_m;
	logic [SYM_W-1:0]  fb;
	logic [SYM_W-1:0]  nsym;
	logic [SCNT_W:0]   kdata;
	logic [SCNT_W:0]   next_cnt;
	logic              at_k;
	logic              last_s;
	logic              err;
	logic              produces;
	logic              bank_free;
	logic              acc;
	logic              out_acc;

	logic [CNT_W-1:0]  out_cnt_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_err_q;

	// Effective T and parity count.
	always_comb begin
		t_lim = fs_q ? N_W'(MAX_T) : N_W'(CAP16);
		if (t_q == '0)
			t_eff = N_W'(1);
		else if ({1'b0, t_q} > t_lim)
			t_eff = t_lim;
		else
			t_eff = {1'b0, t_q};
		n     = {t_eff[N_W-2:0], 1'b0};
		n_m1  = n - N_W'(1);
		n_cnt = CNT_W'(n);
	end

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_FIELD_SELECT ||
			cfg_index == REG_CORRECT_CAPABILITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= 1'b1;
			t_q  <= T_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_FIELD_SELECT)
				fs_q <= cfg_data[0];
			if (cfg_index == REG_CORRECT_CAPABILITY)
				t_q <= cfg_data[T_W-1:0];
		end
	end

	// Generator rebuild: one root multiplied in per cycle.
	assign gctl.init = gen_busy_q && (gen_cnt_q == '0);
	assign gctl.step = gen_busy_q && (gen_cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_busy_q <= 1'b1;
			gen_cnt_q  <= '0;
		end else if (cfg_hit) begin
			gen_busy_q <= 1'b1;
			gen_cnt_q  <= '0;
		end else if (gen_busy_q) begin
			if (gen_cnt_q == n)
				gen_busy_q <= 1'b0;
			gen_cnt_q <= gen_cnt_q + N_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (gctl.init) begin
			root_q <= ALPHA;
		end else if (gctl.step) begin
			root_q <= gf_mul(root_q, ALPHA, fs_q);
		end
	end

	// Data path control.
	always_comb begin
		sym_m     = fs_q ? in_item.data_symbol : (in_item.data_symbol & SYM4_MASK);
		fb        = sym_m ^ p[n_m1[SEL_W-1:0]];
		nsym      = fs_q ? NSYM8 : NSYM4;
		kdata     = {1'b0, nsym} - (SCNT_W+1)'(n);
		next_cnt  = {1'b0, scnt_q} + (SCNT_W+1)'(1);
		at_k      = (next_cnt == kdata);
		last_s    = in_item.last_symbol;
		err       = last_s ^ at_k;
		produces  = last_s | at_k;
		bank_free = (out_cnt_q == '0) || ((out_cnt_q == CNT_W'(1)) && out_ready);
		in_ready  = !gen_busy_q && (!produces || bank_free);
		acc       = in_valid && in_ready;
		out_valid = (out_cnt_q != '0);
		out_acc   = out_valid && out_ready;
	end

	assign pctl.clr     = cfg_hit || (acc && (err || last_s));
	assign pctl.upd     = acc && !err;
	assign pctl.load    = acc && produces;
	assign pctl.ld_zero = err;
	assign pctl.shift   = out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q <= '0;
		end else if (cfg_hit || (acc && (err || last_s))) begin
			scnt_q <= '0;
		end else if (acc) begin
			scnt_q <= next_cnt[SCNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
			out_idx_q <= '0;
			out_err_q <= 1'b0;
		end else if (acc && produces) begin
			out_cnt_q <= err ? CNT_W'(1) : n_cnt;
			out_idx_q <= '0;
			out_err_q <= err;
		end else if (out_acc) begin
			out_cnt_q <= out_cnt_q - CNT_W'(1);
			out_idx_q <= out_idx_q + IDX_W'(1);
		end
	end

	for (genvar j = 0; j < P; j++) begin : g_cell
		rsp_gen_cell u_gen (
			.clk      (clk),
			.ctl      (gctl),
			.wide     (fs_q),
			.init_val ((j == 0) ? GF_ONE : '0),
			.root     (root_q),
			.g_prev   ((j == 0) ? '0 : g[(j == 0) ? 0 : j - 1]),
			.g        (g[j])
		);

		rsp_par_cell u_par (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (pctl),
			.wide    (fs_q),
			.fb      (fb),
			.coeff   (g[j]),
			.p_prev  ((j == 0) ? '0 : p[(j == 0) ? 0 : j - 1]),
			.slot_in ((j == P - 1) ? '0 : slot[(j == P - 1) ? j : j + 1]),
			.p       (p[j]),
			.slot    (slot[j])
		);
	end

	assign out_item.parity_symbol = slot[0];
	assign out_item.parity_index  = out_idx_q;
	assign out_item.last_parity   = (out_cnt_q == CNT_W'(1));
	assign out_item.size_error    = out_err_q;

`ifndef SYNTH
	// A completed block presents exactly 2T parity symbols.
	a_bank_load: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && produces && !err) |=> (out_cnt_q == $past(n_cnt)))
		else $error("parity bank not loaded with 2T symbols");

	// A length error is reported as a single, final result.
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.size_error) |-> out_item.last_parity)
		else $error("size error result is not the last of its run");

	// Parity symbols of a run follow each other without a gap.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !out_item.last_parity) |=> out_valid)
		else $error("parity run interrupted");

	// The generator is rebuilt only after a configuration write.
	a_gen_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(gen_busy_q) |-> $past(cfg_hit))
		else $error("generator rebuild without configuration write");
`endif

endmodule

### rtl/core/rsp_gen_cell.sv
`timescale 1ns / 1ps

module rsp_gen_cell (
	input  logic                       clk,
	input  rsp_pkg::gen_ctl_t          ctl,
	input  logic                       wide,
	input  logic [rsp_pkg::SYM_W-1:0]  init_val,
	input  logic [rsp_pkg::SYM_W-1:0]  root,
	input  logic [rsp_pkg::SYM_W-1:0]  g_prev,
	output logic [rsp_pkg::SYM_W-1:0]  g
);
	import rsp_pkg::*;

	logic [SYM_W-1:0] g_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			g_q <= init_val;
		end else if (ctl.step) begin
			g_q <= g_prev ^ gf_mul(g_q, root, wide);
		end
	end

	assign g = g_q;

endmodule

### rtl/core/rsp_par_cell.sv
`timescale 1ns / 1ps

module rsp_par_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rsp_pkg::par_ctl_t          ctl,
	input  logic                       wide,
	input  logic [rsp_pkg::SYM_W-1:0]  fb,
	input  logic [rsp_pkg::SYM_W-1:0]  coeff,
	input  logic [rsp_pkg::SYM_W-1:0]  p_prev,
	input  logic [rsp_pkg::SYM_W-1:0]  slot_in,
	output logic [rsp_pkg::SYM_W-1:0]  p,
	output logic [rsp_pkg::SYM_W-1:0]  slot
);
	import rsp_pkg::*;

	logic [SYM_W-1:0] p_q;
	logic [SYM_W-1:0] slot_q;
	logic [SYM_W-1:0] p_next;

	assign p_next = p_prev ^ gf_mul(coeff, fb, wide);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (ctl.clr) begin
			p_q <= '0;
		end else if (ctl.upd) begin
			p_q <= p_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_q <= ctl.ld_zero ? '0 : p_next;
		end else if (ctl.shift) begin
			slot_q <= slot_in;
		end
	end

	assign p    = p_q;
	assign slot = slot_q;

endmodule
